[rtl/sfr_pkg.sv]
// Shared types, constants and status helpers for the audio serial FIFO register block.
// No dependencies; imported by every module under rtl/.
package sfr_pkg;

   localparam int FIFO_DEPTH = 8;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int HALF_LEVEL = FIFO_DEPTH / 2;

   localparam logic [31:0] VERSION_WORD = 32'h0201_0000;

   // control word bits
   localparam int CTL_SFTRST  = 31;
   localparam int CTL_CLKGATE = 30;
   localparam int CTL_ERR_EN  = 25;
   localparam int CTL_SVC_EN  = 24;
   localparam int CTL_RXMODE  = 1;
   localparam int CTL_RUN     = 0;

   // status word bits
   localparam int STAT_ALWAYS  = 31;
   localparam int STAT_DMA     = 16;
   localparam int STAT_UNDER   = 6;
   localparam int STAT_OVER    = 5;
   localparam int STAT_SVC     = 4;
   localparam int STAT_RUN     = 0;

   // error flag bits
   localparam int ERR_UNDER = 1;
   localparam int ERR_OVER  = 0;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_TICK  = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_CTRL = 2'd0,
      REG_STAT = 2'd1,
      REG_DATA = 2'd2,
      REG_VER  = 2'd3
   } reg_type;

   typedef enum logic [1:0] {
      ALIAS_PLAIN  = 2'd0,
      ALIAS_SET    = 2'd1,
      ALIAS_CLEAR  = 2'd2,
      ALIAS_TOGGLE = 2'd3
   } alias_type;

   // FIFO chain control from the register logic
   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } fifo_ctl_type;

   // FIFO chain fill level, current and after this cycle
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] count_next;
   } fifo_stat_type;

   function automatic logic is_running(input logic [31:0] ctl);
      return ctl[CTL_RUN] & ~ctl[CTL_CLKGATE] & ~ctl[CTL_SFTRST];
   endfunction

   function automatic logic [31:0] status_word(input logic [31:0] ctl,
                                               input logic [1:0] err,
                                               input logic [CNT_W-1:0] cnt);
      logic [31:0]      st;
      logic [CNT_W-1:0] half;
      logic             rx;
      st   = '0;
      half = CNT_W'(HALF_LEVEL);
      rx   = ctl[CTL_RXMODE];
      st[STAT_ALWAYS]  = 1'b1;
      st[STAT_UNDER]   = err[ERR_UNDER];
      st[STAT_OVER]    = err[ERR_OVER];
      st[STAT_SVC]     = rx ? (cnt >= half) : (cnt <= half);
      st[STAT_RUN]     = is_running(ctl);
      st[STAT_DMA]     = is_running(ctl) & (rx ? (cnt > half) : (cnt < half));
      return st;
   endfunction

endpackage

[rtl/sfr_cell.sv]
// One FIFO cell: holds a single word, loads a pushed word or takes its neighbor's on a pop.
// Depends on sfr_pkg.
module sfr_cell (
   input  logic        clock,
   input  logic        shift_en,
   input  logic        load_en,
   input  logic [31:0] nbr_word,
   input  logic [31:0] load_word,
   output logic [31:0] cell_word
);
   import sfr_pkg::*;

   logic [31:0] word_ff;
   logic [31:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (shift_en) begin
         word_in = nbr_word;
      end else if (load_en) begin
         word_in = load_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign cell_word = word_ff;

endmodule

[rtl/sfr_chain.sv]
// Shift FIFO built as a row of sfr_cell; cell 0 is always the head word.
// Depends on sfr_pkg and sfr_cell.
module sfr_chain (
   input  logic                  clock,
   input  logic                  reset,
   input  sfr_pkg::fifo_ctl_type ctl,
   input  logic [31:0]           push_word,
   output sfr_pkg::fifo_stat_type stat,
   output logic [31:0]           head_word
);
   import sfr_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [31:0]      words [FIFO_DEPTH];

   // pushes land at the fill level; pops shift every cell down by one
   for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
      logic [31:0] nbr;
      if (i == FIFO_DEPTH - 1) begin : g_last
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = words[i+1];
      end
      sfr_cell u_cell (
         .clock     (clock),
         .shift_en  (ctl.pop),
         .load_en   (ctl.push && (count_ff == CNT_W'(i))),
         .nbr_word  (nbr),
         .load_word (push_word),
         .cell_word (words[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.flush) begin
         count_in = '0;
      end else if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.count      = count_ff;
   assign stat.count_next = count_in;
   assign head_word       = words[0];

endmodule

[rtl/serial_audio_fifo_regs.sv]
// Top level of the audio serial interface register block with its shared frame FIFO.
// Depends on sfr_pkg and sfr_chain (which uses sfr_cell).
//
//   channel | dir | tdata (low bit up)                          | tuser (low bit up)
//   --------+-----+---------------------------------------------+--------------------------
//   req_    | in  | write_data[31:0], capture_frame[63:32]      | mode[1:0], reg_index[3:2],
//           |     |                                             | alias_req[5:4]
//   rsp_    | out | read_data[31:0], play_frame[63:32],         | play_valid[0]
//           |     | dma_request[64], irq[65], zero pad [71:66]  |
//
// For each transaction the register update, the FIFO push or pop and the status
// evaluation happen on the accepting edge and the result lands in the output register.
// The FIFO is a row of shift cells. A new request is taken while the output register
// is empty or being drained, so the block sustains one transaction per clock; a
// stalled rsp_ side holds off req_.
// Synchronous active-high reset clears control, error flags, FIFO level and rsp_tvalid;
// FIFO words are left as they are and are never read before being written.
module serial_audio_fifo_regs (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // write_data, capture_frame
   input  logic [5:0]  req_tuser,   // mode, reg_index, alias_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // read_data, play_frame, dma_request, irq, pad
   output logic [0:0]  rsp_tuser    // play_valid
);
   import sfr_pkg::*;

   // architectural state
   logic [31:0] ctl_ff, ctl_in;
   logic [1:0]  err_ff, err_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rd_ff, rd_in;
   logic [31:0] pf_ff, pf_in;
   logic        pv_ff, pv_in;
   logic        dma_ff, dma_in;
   logic        irq_ff, irq_in;

   // request unpacking
   logic        accept;
   mode_type    mode;
   reg_type     reg_sel;
   alias_type   alias_sel;
   logic [31:0] write_data;
   logic [31:0] capture_frame;

   fifo_ctl_type  fctl;
   fifo_stat_type fstat;
   logic [31:0]   push_word;
   logic [31:0]   head_word;
   logic [31:0]   st_next;
   logic [1:0]    err_mask;

   assign req_tready    = !rsp_valid_ff || rsp_tready;
   assign accept        = req_tvalid && req_tready;
   assign mode          = mode_type'(req_tuser[1:0]);
   assign reg_sel       = reg_type'(req_tuser[3:2]);
   assign alias_sel     = alias_type'(req_tuser[5:4]);
   assign write_data    = req_tdata[31:0];
   assign capture_frame = req_tdata[63:32];

   sfr_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fctl),
      .push_word (push_word),
      .stat      (fstat),
      .head_word (head_word)
   );

   // Transaction decode. Push and pop are gated here by the current level, so the
   // chain never sees a push when full or a pop when empty.
   always_comb begin
      ctl_in    = ctl_ff;
      err_in    = err_ff;
      fctl      = '0;
      push_word = write_data;
      rd_in     = '0;
      pf_in     = '0;
      pv_in     = 1'b0;
      err_mask  = {write_data[STAT_UNDER], write_data[STAT_OVER]};

      if (accept) begin
         unique case (mode)
            MODE_READ: begin
               unique case (reg_sel)
                  REG_CTRL: rd_in = ctl_ff;
                  REG_STAT: rd_in = status_word(ctl_ff, err_ff, fstat.count);
                  REG_DATA: begin
                     if (fstat.count != '0) begin
                        rd_in    = head_word;
                        fctl.pop = 1'b1;
                     end else begin
                        err_in[ERR_UNDER] = 1'b1;
                     end
                  end
                  REG_VER:  rd_in = VERSION_WORD;
                  default:  rd_in = '0;
               endcase
            end
            MODE_WRITE: begin
               unique case (reg_sel)
                  REG_CTRL: begin
                     unique case (alias_sel)
                        ALIAS_PLAIN:  ctl_in = write_data;
                        ALIAS_SET:    ctl_in = ctl_ff | write_data;
                        ALIAS_CLEAR:  ctl_in = ctl_ff & ~write_data;
                        ALIAS_TOGGLE: ctl_in = ctl_ff ^ write_data;
                        default:      ctl_in = ctl_ff;
                     endcase
                     // leaving soft reset empties the FIFO
                     fctl.flush = ctl_ff[CTL_SFTRST] & ~ctl_in[CTL_SFTRST];
                  end
                  REG_STAT: begin
                     // only the set alias sets flags; every other alias is W1C
                     if (alias_sel == ALIAS_SET) begin
                        err_in = err_ff | err_mask;
                     end else begin
                        err_in = err_ff & ~err_mask;
                     end
                  end
                  REG_DATA: begin
                     if (fstat.count != CNT_W'(FIFO_DEPTH)) begin
                        fctl.push = 1'b1;
                     end else begin
                        err_in[ERR_OVER] = 1'b1;
                     end
                  end
                  REG_VER:  ;
                  default:  ;
               endcase
            end
            MODE_TICK: begin
               if (is_running(ctl_ff)) begin
                  if (ctl_ff[CTL_RXMODE]) begin
                     push_word = capture_frame;
                     if (fstat.count != CNT_W'(FIFO_DEPTH)) begin
                        fctl.push = 1'b1;
                     end else begin
                        err_in[ERR_OVER] = 1'b1;
                     end
                  end else begin
                     pv_in = 1'b1;
                     if (fstat.count != '0) begin
                        pf_in    = head_word;
                        fctl.pop = 1'b1;
                     end else begin
                        err_in[ERR_UNDER] = 1'b1;
                     end
                  end
               end
            end
            MODE_NOP: ;
            default:  ;
         endcase
      end

      // status after this transaction
      st_next = status_word(ctl_in, err_in, fstat.count_next);
      dma_in  = st_next[STAT_DMA];
      irq_in  = (st_next[STAT_SVC] & ctl_in[CTL_SVC_EN]) |
                ((st_next[STAT_UNDER] | st_next[STAT_OVER]) & ctl_in[CTL_ERR_EN]);

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= '0;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload only moves on an accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff  <= rd_in;
         pf_ff  <= pf_in;
         pv_ff  <= pv_in;
         dma_ff <= dma_in;
         irq_ff <= irq_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, irq_ff, dma_ff, pf_ff, rd_ff};
   assign rsp_tuser  = pv_ff;

   // FIFO level never passes its depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      fstat.count <= CNT_W'(FIFO_DEPTH))
      else $error("FIFO level above depth");

   // leaving soft reset leaves the FIFO empty
   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      fctl.flush |=> (fstat.count == '0))
      else $error("FIFO not empty after soft reset release");

   // no frame is played without a transmit tick
   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !pv_ff) |-> (pf_ff == '0))
      else $error("play frame nonzero without play valid");

   // a DMA request only shows while the interface runs
   a_dma_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && dma_ff) |-> is_running(ctl_ff))
      else $error("DMA request while not running");

endmodule

[test/tb.sv]
// Self-checking bench for serial_audio_fifo_regs: register, FIFO and frame-tick transactions.
// Depends on sfr_pkg (enums, bit positions, FIFO depth) and the serial_audio_fifo_regs RTL.
`timescale 1ns / 1ps

module tb;
   import sfr_pkg::*;

   // One request transaction, field for field as carried on req_.
   typedef struct packed {
      mode_type    op;
      reg_type     reg_sel;
      alias_type   alias_sel;
      logic [31:0] wr_data;
      logic [31:0] cap_frame;
   } access_type;

   // One response transaction as carried on rsp_.
   typedef struct packed {
      logic [31:0] rd_data;
      logic        play_vld;
      logic [31:0] play_data;
      logic        dma;
      logic        irq;
   } reply_type;

   // Stimulus burst flavors: fill, tick and drain each lean on one way of moving the FIFO level.
   typedef enum int {
      BURST_FILL,
      BURST_TICK,
      BURST_DRAIN,
      BURST_MIX
   } burst_kind_type;

   localparam int RANDOM_ITEMS = 1100;
   localparam int PHASE_LEN    = 275;     // accepted transactions per idling phase
   localparam int HOLD_AT      = 120;     // where the long response hold-off starts
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // write_data, capture_frame
   logic [5:0]  req_tuser = '0;   // mode, reg_index, alias_req
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // read_data, play_frame, dma_request, irq, pad
   logic [0:0]  rsp_tuser;        // play_valid

   // Shadow of the block's state, updated as each transaction is accepted.
   logic [31:0] shd_ctrl;
   logic [1:0]  shd_err;
   logic [31:0] shd_fifo [FIFO_DEPTH];
   int          shd_head;
   int          shd_count;

   access_type access_q[$];       // transactions not yet offered
   reply_type  reply_q[$];        // responses owed by the block, oldest first
   access_type cur_acc;           // transaction currently on req_
   int      n_total    = 0;
   int      n_accepted = 0;
   int      n_errors   = 0;
   int      hold_left  = 0;
   bit      hold_done  = 1'b0;
   int      cycle_cnt  = 0;

   serial_audio_fifo_regs i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- shadow model

   function automatic logic core_on();
      return shd_ctrl[CTL_RUN] && !shd_ctrl[CTL_CLKGATE] && !shd_ctrl[CTL_SFTRST];
   endfunction

   function automatic logic [31:0] stat_value();
      logic [31:0] st;
      logic        rx;
      st = '0;
      rx = shd_ctrl[CTL_RXMODE];
      st[STAT_ALWAYS]  = 1'b1;
      st[STAT_UNDER]   = shd_err[ERR_UNDER];
      st[STAT_OVER]    = shd_err[ERR_OVER];
      st[STAT_SVC]     = rx ? (shd_count >= HALF_LEVEL) : (shd_count <= HALF_LEVEL);
      if (core_on()) begin
         st[STAT_RUN]  = 1'b1;
         st[STAT_DMA]  = rx ? (shd_count > HALF_LEVEL) : (shd_count < HALF_LEVEL);
      end
      return st;
   endfunction

   // full FIFO: the word is dropped and overflow sticks
   function automatic void fifo_put(logic [31:0] v);
      if (shd_count < FIFO_DEPTH) begin
         shd_fifo[(shd_head + shd_count) % FIFO_DEPTH] = v;
         shd_count++;
      end else begin
         shd_err[ERR_OVER] = 1'b1;
      end
   endfunction

   // empty FIFO: reads zero and underflow sticks
   function automatic logic [31:0] fifo_take();
      logic [31:0] v;
      v = '0;
      if (shd_count > 0) begin
         v = shd_fifo[shd_head];
         shd_head = (shd_head + 1) % FIFO_DEPTH;
         shd_count--;
      end else begin
         shd_err[ERR_UNDER] = 1'b1;
      end
      return v;
   endfunction

   // Applies one accepted transaction to the shadow state and returns the response it owes.
   function automatic reply_type apply_access(access_type a);
      reply_type   r;
      logic [31:0] prev, nxt, st;
      logic [1:0]  msk;
      r = '0;
      case (a.op)
         MODE_READ: begin
            case (a.reg_sel)
               REG_CTRL: r.rd_data = shd_ctrl;
               REG_STAT: r.rd_data = stat_value();
               REG_DATA: r.rd_data = fifo_take();
               default:  r.rd_data = VERSION_WORD;
            endcase
         end
         MODE_WRITE: begin
            case (a.reg_sel)
               REG_CTRL: begin
                  prev = shd_ctrl;
                  case (a.alias_sel)
                     ALIAS_PLAIN: nxt = a.wr_data;
                     ALIAS_SET:   nxt = prev | a.wr_data;
                     ALIAS_CLEAR: nxt = prev & ~a.wr_data;
                     default:     nxt = prev ^ a.wr_data;
                  endcase
                  // leaving soft reset empties the FIFO
                  if (prev[CTL_SFTRST] && !nxt[CTL_SFTRST]) begin
                     shd_count = 0;
                     shd_head  = 0;
                  end
                  shd_ctrl = nxt;
               end
               REG_STAT: begin
                  msk = '0;
                  msk[ERR_UNDER] = a.wr_data[STAT_UNDER];
                  msk[ERR_OVER]  = a.wr_data[STAT_OVER];
                  if (a.alias_sel == ALIAS_SET) shd_err = shd_err | msk;
                  else shd_err = shd_err & ~msk;
               end
               REG_DATA: fifo_put(a.wr_data);
               default: ;
            endcase
         end
         MODE_TICK: begin
            if (core_on()) begin
               if (shd_ctrl[CTL_RXMODE]) begin
                  fifo_put(a.cap_frame);
               end else begin
                  r.play_data = fifo_take();
                  r.play_vld  = 1'b1;
               end
            end
         end
         default: ;
      endcase
      st    = stat_value();
      r.dma = st[STAT_DMA];
      r.irq = (st[STAT_SVC] && shd_ctrl[CTL_SVC_EN]) ||
              ((st[STAT_UNDER] || st[STAT_OVER]) && shd_ctrl[CTL_ERR_EN]);
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic access_type acc(mode_type op, reg_type rs, alias_type al,
                                      logic [31:0] wd, logic [31:0] cap);
      access_type a;
      a.op        = op;
      a.reg_sel   = rs;
      a.alias_sel = al;
      a.wr_data   = wd;
      a.cap_frame = cap;
      return a;
   endfunction

   // Control values are mostly sane (running, no gate, no soft reset) so the FIFO
   // keeps moving; now and then a fully random one or a soft reset entry.
   function automatic access_type ctrl_write();
      access_type a;
      int         k;
      a = acc(MODE_WRITE, REG_CTRL, alias_type'($urandom_range(3)), $urandom, $urandom);
      k = $urandom_range(9);
      if (k == 1) begin
         a.alias_sel = ALIAS_PLAIN;
         a.wr_data[CTL_SFTRST] = 1'b1;
      end else if (k != 0) begin
         a.alias_sel = ALIAS_PLAIN;
         a.wr_data[CTL_SFTRST]  = 1'b0;
         a.wr_data[CTL_CLKGATE] = 1'b0;
         a.wr_data[CTL_RUN]     = ($urandom_range(7) != 0);
      end
      return a;
   endfunction

   function automatic access_type random_access(burst_kind_type kind);
      access_type a;
      int         p_push, p_tick, p_pop, r, r2;
      case (kind)
         BURST_FILL:  begin p_push = 60; p_tick = 15; p_pop = 10; end
         BURST_TICK:  begin p_push = 10; p_tick = 60; p_pop = 15; end
         BURST_DRAIN: begin p_push = 10; p_tick = 15; p_pop = 60; end
         default:     begin p_push = 25; p_tick = 25; p_pop = 25; end
      endcase
      a = acc(MODE_READ, REG_DATA, alias_type'($urandom_range(3)), $urandom, $urandom);
      r = $urandom_range(99);
      if (r < p_push) begin
         a.op = MODE_WRITE;
      end else if (r < p_push + p_tick) begin
         a.op = MODE_TICK;
         a.reg_sel = reg_type'($urandom_range(3));
      end else if (r < p_push + p_tick + p_pop) begin
         a.op = MODE_READ;
      end else begin
         r2 = $urandom_range(99);
         if (r2 < 30) begin
            a = ctrl_write();
         end else if (r2 < 55) begin
            a.op = MODE_WRITE;
            a.reg_sel = REG_STAT;
         end else if (r2 < 80) begin
            a.op = MODE_READ;
            case ($urandom_range(2))
               0:       a.reg_sel = REG_CTRL;
               1:       a.reg_sel = REG_STAT;
               default: a.reg_sel = REG_VER;
            endcase
         end else if (r2 < 90) begin
            a.op = MODE_WRITE;
            a.reg_sel = REG_VER;
         end else begin
            a.op = MODE_NOP;
            a.reg_sel = reg_type'($urandom_range(3));
         end
      end
      return a;
   endfunction

   task automatic build_directed();
      int i;
      access_q.push_back(acc(MODE_READ,  REG_VER,  ALIAS_PLAIN,  '0, '0));
      access_q.push_back(acc(MODE_WRITE, REG_VER,  ALIAS_TOGGLE, '1, '1));  // ignored
      access_q.push_back(acc(MODE_READ,  REG_DATA, ALIAS_PLAIN,  '0, '0));  // empty pop
      access_q.push_back(acc(MODE_WRITE, REG_STAT, ALIAS_SET,    '1, '0));
      access_q.push_back(acc(MODE_READ,  REG_STAT, ALIAS_CLEAR,  '0, '0));
      access_q.push_back(acc(MODE_WRITE, REG_STAT, ALIAS_TOGGLE, 32'h40, '0));
      access_q.push_back(acc(MODE_WRITE, REG_STAT, ALIAS_CLEAR,  32'h20, '0));
      access_q.push_back(acc(MODE_WRITE, REG_STAT, ALIAS_SET,    32'h20, '0));
      access_q.push_back(acc(MODE_WRITE, REG_STAT, ALIAS_PLAIN,  '1, '0));
      // soft reset held with run and both irq enables: ticks do nothing
      access_q.push_back(acc(MODE_WRITE, REG_CTRL, ALIAS_PLAIN,  32'h8300_0001, '0));
      access_q.push_back(acc(MODE_TICK,  REG_CTRL, ALIAS_PLAIN,  '0, $urandom));
      access_q.push_back(acc(MODE_WRITE, REG_DATA, ALIAS_SET,    '1, '0));
      access_q.push_back(acc(MODE_WRITE, REG_DATA, ALIAS_CLEAR,  '0, '0));
      access_q.push_back(acc(MODE_READ,  REG_CTRL, ALIAS_PLAIN,  '0, '0));
      // release soft reset: FIFO flushed, transmit running, first tick underflows
      access_q.push_back(acc(MODE_WRITE, REG_CTRL, ALIAS_CLEAR,  32'h8000_0000, '0));
      access_q.push_back(acc(MODE_TICK,  REG_DATA, ALIAS_PLAIN,  '0, '0));
      for (i = 0; i <= FIFO_DEPTH; i++) begin   // last push overflows
         access_q.push_back(acc(MODE_WRITE, REG_DATA, alias_type'(i % 4), $urandom, '0));
      end
      access_q.push_back(acc(MODE_TICK,  REG_DATA, ALIAS_PLAIN,  '0, '0));
      access_q.push_back(acc(MODE_TICK,  REG_DATA, ALIAS_PLAIN,  '0, '0));
      // gate the clock and go to receive mode, then ungate
      access_q.push_back(acc(MODE_WRITE, REG_CTRL, ALIAS_TOGGLE, 32'h4000_0002, '0));
      access_q.push_back(acc(MODE_TICK,  REG_DATA, ALIAS_PLAIN,  '0, '1));
      access_q.push_back(acc(MODE_WRITE, REG_CTRL, ALIAS_TOGGLE, 32'h4000_0000, '0));
      access_q.push_back(acc(MODE_TICK,  REG_DATA, ALIAS_PLAIN,  '0, '1));
      access_q.push_back(acc(MODE_TICK,  REG_DATA, ALIAS_PLAIN,  '0, '0));
      access_q.push_back(acc(MODE_TICK,  REG_DATA, ALIAS_PLAIN,  '0, $urandom)); // full
      access_q.push_back(acc(MODE_READ,  REG_DATA, ALIAS_TOGGLE, '0, '0));
      access_q.push_back(acc(MODE_NOP,   REG_DATA, ALIAS_PLAIN,  '1, '1));
      access_q.push_back(acc(MODE_READ,  REG_STAT, ALIAS_PLAIN,  '0, '0));
      access_q.push_back(acc(MODE_WRITE, REG_CTRL, ALIAS_PLAIN,  '1, '0));
      access_q.push_back(acc(MODE_WRITE, REG_CTRL, ALIAS_PLAIN,  '0, '0));
   endtask

   // Random part in bursts so the FIFO swings between empty and full in both modes.
   task automatic build_random();
      int             n, len, i;
      burst_kind_type kind;
      n = 0;
      while (n < RANDOM_ITEMS) begin
         kind = burst_kind_type'($urandom_range(3));
         len  = $urandom_range(16, 4);
         for (i = 0; i < len; i++) begin
            access_q.push_back(random_access(kind));
         end
         n += len;
      end
   endtask

   // ---------------------------------------------------------------- idling phases

   function automatic int sender_idle_pct();
      case (n_accepted / PHASE_LEN)
         0:       return 0;
         1:       return 87;
         2:       return 0;
         default: return 19;
      endcase
   endfunction

   function automatic int recv_stall_pct();
      case (n_accepted / PHASE_LEN)
         0:       return 0;
         1:       return 0;
         2:       return 87;
         default: return 19;
      endcase
   endfunction

   // ---------------------------------------------------------------- driver

   // On an accepting edge the transaction on req_ is applied to the shadow state;
   // the next one is offered unless the sender idles. A transaction that is not
   // yet taken stays on the bus unchanged.
   always @(posedge clock) begin : drive_proc
      reply_type rep;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rep = apply_access(cur_acc);
            reply_q.push_back(rep);
            n_accepted <= n_accepted + 1;
         end
         if (req_tvalid && !req_tready) begin
            // stalled: hold the current transaction
         end else if (access_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
            cur_acc = access_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {cur_acc.cap_frame, cur_acc.wr_data};
            req_tuser  <= {cur_acc.alias_sel, cur_acc.reg_sel, cur_acc.op};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- back-pressure

   // One long hold-off on rsp_ while the sender keeps offering, so the output
   // register fills and req_tready has to drop.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && n_accepted == HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         n_errors++;
         if (n_errors <= 10)
            $display("%0t: %s mismatch: expected %08h, got %08h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_proc
      reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("%0t: response transaction with none outstanding", $time);
            end else begin
               want = reply_q.pop_front();
               check_field("read_data",   rsp_tdata[31:0],       want.rd_data);
               check_field("play_frame",  rsp_tdata[63:32],      want.play_data);
               check_field("dma_request", 32'(rsp_tdata[64]),    32'(want.dma));
               check_field("irq",         32'(rsp_tdata[65]),    32'(want.irq));
               check_field("play_valid",  32'(rsp_tuser[0]),     32'(want.play_vld));
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct());
      end
   end

   // ---------------------------------------------------------------- run control

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : run_proc
      int i;
      build_directed();
      build_random();
      n_total = access_q.size();
      // shadow reset state; the FIFO words are cleared only for tidiness
      shd_ctrl  = '0;
      shd_err   = '0;
      shd_head  = 0;
      shd_count = 0;
      for (i = 0; i < FIFO_DEPTH; i++) shd_fifo[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (n_accepted == n_total);
      wait (reply_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_errors == 0 && reply_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
